FILE: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge; skipped while reset is asserted.
`define CHK_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("check failed");

// Checked on every rising edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("check failed");

`endif

FILE: src/bscs_pkg.sv
`timescale 1ns / 1ps
package bscs_pkg;
  localparam int MaxSets     = 1024;
  localparam int MaxElements = 256;
  localparam int MaxBudget   = 6;
  localparam int WordBits    = 64;
  localparam int NWords      = (MaxElements + WordBits - 1) / WordBits;

  localparam int SetIdxW  = $clog2(MaxSets);
  localparam int WordSelW = $clog2(NWords);
  localparam int BitSelW  = $clog2(WordBits);
  localparam int ElemW    = $clog2(MaxElements);
  localparam int MaskAddrW = SetIdxW + WordSelW;
  localparam int WidthW   = 9;
  localparam int BudgetW  = 3;
  localparam int SetCntW  = 11;
  localparam int CostW    = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 11;

  localparam logic [CfgIdxW-1:0] CfgUniverse = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBudget   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSetCount = 2'd2;

  // Cost codes zero and three stand for one and two.
  function automatic logic [CostW-1:0] eff_cost(input logic [CostW-1:0] c);
    logic [CostW-1:0] r;
    r = c;
    if (c == 2'd0) r = 2'd1;
    if (c == 2'd3) r = 2'd2;
    return r;
  endfunction
endpackage

FILE: src/bscs_if.sv
`timescale 1ns / 1ps
interface bscs_in_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [bscs_pkg::SetIdxW-1:0]     set_index;
  logic [bscs_pkg::CostW-1:0]       cost;
  logic [bscs_pkg::WordSelW-1:0]    word_index;
  logic [bscs_pkg::WordBits-1:0]    mask_word;
  modport source(output valid, mode, set_index, cost, word_index, mask_word, input ready);
  modport sink(input valid, mode, set_index, cost, word_index, mask_word, output ready);
endinterface

interface bscs_out_if;
  logic                         valid;
  logic                         ready;
  logic                         satisfiable;
  logic                         has_set;
  logic [bscs_pkg::SetIdxW-1:0] chosen_index;
  logic                         last;
  modport source(output valid, satisfiable, has_set, chosen_index, last, input ready);
  modport sink(input valid, satisfiable, has_set, chosen_index, last, output ready);
endinterface

interface bscs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bscs_pkg::CfgIdxW-1:0]  index;
  logic [bscs_pkg::CfgDataW-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: src/bscs_ram.sv
`timescale 1ns / 1ps
module bscs_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: src/budgeted_set_cover_search_unit.sv
`timescale 1ns / 1ps
// Load transaction: the mask word and cost go straight into memory.
// Search transaction: counting of covering sets per element, ranking of the
// elements, then a backtracking search that probes elements and tries sets;
// one result per cycle after that, while the output is not stalled.
// The input is ready again once the last result sits in the output register.
// Reset clears the sequencer, output valid and config (width 256, budget 6, sets 0).
module budgeted_set_cover_search_unit (
  input  logic  clk_i,
  input  logic  rst_ni,
  bscs_in_if.sink   in_i,
  bscs_out_if.source out_o,
  bscs_cfg_if.sink  cfg_i
);
  localparam int Ne  = bscs_pkg::MaxElements;
  localparam int Nb  = bscs_pkg::MaxBudget;
  localparam int Wb  = bscs_pkg::WordBits;
  localparam int SiW = bscs_pkg::SetIdxW;
  localparam int EW  = bscs_pkg::ElemW;
  localparam int WW  = bscs_pkg::WidthW;
  localparam int BW  = bscs_pkg::BudgetW;
  localparam int ScW = bscs_pkg::SetCntW;
  localparam int CW  = bscs_pkg::CostW;
  localparam int SW  = bscs_pkg::WordSelW;
  localparam int DW  = $clog2(Nb);

  localparam logic [4:0] StIdle    = 5'd0;
  localparam logic [4:0] StCntRd   = 5'd1;
  localparam logic [4:0] StCntUse  = 5'd2;
  localparam logic [4:0] StSrtKey  = 5'd3;
  localparam logic [4:0] StSrtKey2 = 5'd4;
  localparam logic [4:0] StSrtRd   = 5'd5;
  localparam logic [4:0] StSrtUse  = 5'd6;
  localparam logic [4:0] StNode    = 5'd7;
  localparam logic [4:0] StFindRd  = 5'd8;
  localparam logic [4:0] StFindUse = 5'd9;
  localparam logic [4:0] StSetRd   = 5'd10;
  localparam logic [4:0] StSetUse  = 5'd11;
  localparam logic [4:0] StTwRd    = 5'd12;
  localparam logic [4:0] StTwUse   = 5'd13;
  localparam logic [4:0] StTest    = 5'd14;
  localparam logic [4:0] StFail    = 5'd15;
  localparam logic [4:0] StEmit    = 5'd16;
  localparam logic [4:0] StUnsat   = 5'd17;

  logic [4:0]   state_q, state_d;
  logic [WW-1:0] uw_q, uw_d;
  logic [BW-1:0] bud_q, bud_d;
  logic [ScW-1:0] sc_q, sc_d;
  logic          ov_q, ov_d;
  logic          o_sat_q, o_sat_d, o_has_q, o_has_d, o_last_q, o_last_d;
  logic [SiW-1:0] o_idx_q, o_idx_d;

  logic [WW-1:0]  effw_q, effw_d;
  logic [ScW-1:0] effs_q, effs_d;
  logic [WW-1:0]  e_q, e_d, j_q, j_d, i_q, i_d;
  logic [ScW-1:0] s_q, s_d;
  logic [ScW-1:0] c1_q, c1_d, c2_q, c2_d, key0_q, key0_d, key1_q, key1_d;
  logic [EW-1:0]  rk0_q, rk0_d, rk1_q, rk1_d, row_q, row_d;
  logic [Ne-1:0]  r_q, r_d, t_q, t_d;
  logic [BW-1:0]  cap_q, cap_d;
  logic [CW-1:0]  c_q, c_d;
  logic [DW-1:0]  dep_q, dep_d, k_q, k_d;
  logic [SW-1:0]  wk_q, wk_d;
  logic [Ne-1:0]  stk_r_q [Nb];
  logic [Ne-1:0]  stk_r_d [Nb];
  logic [BW-1:0]  stk_cap_q [Nb];
  logic [BW-1:0]  stk_cap_d [Nb];
  logic [SiW-1:0] stk_s_q [Nb];
  logic [SiW-1:0] stk_s_d [Nb];
  logic [EW-1:0]  stk_row_q [Nb];
  logic [EW-1:0]  stk_row_d [Nb];

  // Memory ports.
  logic                            mask_we, cost_we, cnt_we, ord_we;
  logic [bscs_pkg::MaskAddrW-1:0]  mask_waddr, mask_raddr;
  logic [Wb-1:0]                   mask_rd;
  logic [CW-1:0]                   cost_rd;
  logic [EW-1:0]                   cnt_waddr, cnt_raddr, ord_waddr0, ord_waddr1;
  logic [ScW-1:0]                  cnt0_rd, cnt1_rd;
  logic [EW-1:0]                   ord0_rd, ord1_rd;

  logic          in_acc, out_free, lv2, t_zero;
  logic [CW-1:0] ce;
  logic [EW-1:0] fe;
  logic [DW-1:0] dep_m1;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !ov_q || out_o.ready;
  assign lv2      = cap_q >= 3'd2;
  assign t_zero   = (t_q == '0);
  assign ce       = bscs_pkg::eff_cost(cost_rd);
  assign fe       = lv2 ? ord1_rd : ord0_rd;
  assign dep_m1   = DW'(dep_q - DW'(1));

  assign in_i.ready         = (state_q == StIdle);
  assign cfg_i.ready        = 1'b1;
  assign out_o.valid        = ov_q;
  assign out_o.satisfiable  = o_sat_q;
  assign out_o.has_set      = o_has_q;
  assign out_o.chosen_index = o_idx_q;
  assign out_o.last         = o_last_q;

  assign mask_we    = in_acc && !in_i.mode;
  assign cost_we    = mask_we;
  assign mask_waddr = {in_i.set_index, in_i.word_index};
  assign cnt_waddr  = e_q[EW-1:0];
  assign ord_waddr0 = rk0_q;
  assign ord_waddr1 = rk1_q;
  assign cnt_we     = (state_q == StCntRd) && (s_q == effs_q);
  assign ord_we     = (state_q == StSrtRd) && (j_q == effw_q);
  assign cnt_raddr  = (state_q == StSrtKey) ? e_q[EW-1:0] : j_q[EW-1:0];

  always_comb begin
    case (state_q)
      StCntRd: mask_raddr = {s_q[SiW-1:0], e_q[EW-1:bscs_pkg::BitSelW]};
      StSetRd: mask_raddr = {s_q[SiW-1:0], row_q[EW-1:bscs_pkg::BitSelW]};
      default: mask_raddr = {s_q[SiW-1:0], wk_q};
    endcase
  end

  bscs_ram #(.Width(Wb), .Depth(bscs_pkg::MaxSets * bscs_pkg::NWords)) u_mask (
    .clk_i, .we_i(mask_we), .waddr_i(mask_waddr), .wdata_i(in_i.mask_word),
    .raddr_i(mask_raddr), .rdata_o(mask_rd));
  bscs_ram #(.Width(CW), .Depth(bscs_pkg::MaxSets)) u_cost (
    .clk_i, .we_i(cost_we), .waddr_i(in_i.set_index), .wdata_i(in_i.cost),
    .raddr_i(s_q[SiW-1:0]), .rdata_o(cost_rd));
  bscs_ram #(.Width(ScW), .Depth(Ne)) u_cnt0 (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(c1_q),
    .raddr_i(cnt_raddr), .rdata_o(cnt0_rd));
  bscs_ram #(.Width(ScW), .Depth(Ne)) u_cnt1 (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(c2_q),
    .raddr_i(cnt_raddr), .rdata_o(cnt1_rd));
  bscs_ram #(.Width(EW), .Depth(Ne)) u_ord0 (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr0), .wdata_i(e_q[EW-1:0]),
    .raddr_i(i_q[EW-1:0]), .rdata_o(ord0_rd));
  bscs_ram #(.Width(EW), .Depth(Ne)) u_ord1 (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr1), .wdata_i(e_q[EW-1:0]),
    .raddr_i(i_q[EW-1:0]), .rdata_o(ord1_rd));

  always_comb begin
    state_d = state_q;
    uw_d = uw_q; bud_d = bud_q; sc_d = sc_q;
    ov_d = ov_q && !out_o.ready;
    o_sat_d = o_sat_q; o_has_d = o_has_q; o_idx_d = o_idx_q; o_last_d = o_last_q;
    effw_d = effw_q; effs_d = effs_q;
    e_d = e_q; j_d = j_q; i_d = i_q; s_d = s_q;
    c1_d = c1_q; c2_d = c2_q; key0_d = key0_q; key1_d = key1_q;
    rk0_d = rk0_q; rk1_d = rk1_q; row_d = row_q;
    r_d = r_q; t_d = t_q; cap_d = cap_q; c_d = c_q;
    dep_d = dep_q; k_d = k_q; wk_d = wk_q;
    stk_r_d = stk_r_q; stk_cap_d = stk_cap_q; stk_s_d = stk_s_q; stk_row_d = stk_row_q;

    if (cfg_i.valid) begin
      case (cfg_i.index)
        bscs_pkg::CfgUniverse: uw_d  = cfg_i.data[WW-1:0];
        bscs_pkg::CfgBudget:   bud_d = cfg_i.data[BW-1:0];
        bscs_pkg::CfgSetCount: sc_d  = cfg_i.data[ScW-1:0];
        default: ;
      endcase
    end

    case (state_q)
      StIdle: begin
        if (in_acc && in_i.mode) begin
          if (uw_q == '0) effw_d = WW'(1);
          else if (uw_q > WW'(Ne)) effw_d = WW'(Ne);
          else effw_d = uw_q;
          effs_d = (sc_q > ScW'(bscs_pkg::MaxSets)) ? ScW'(bscs_pkg::MaxSets) : sc_q;
          cap_d  = (bud_q > BW'(Nb)) ? BW'(Nb) : bud_q;
          e_d = '0; s_d = '0; c1_d = '0; c2_d = '0;
          state_d = StCntRd;
        end
      end
      // Count, for element e, the cost-one and all covering sets.
      StCntRd: begin
        if (s_q == effs_q) begin
          s_d = '0; c1_d = '0; c2_d = '0;
          e_d = WW'(e_q + WW'(1));
          if (WW'(e_q + WW'(1)) == effw_q) begin
            e_d = '0;
            state_d = StSrtKey;
          end
        end else begin
          state_d = StCntUse;
        end
      end
      StCntUse: begin
        if (mask_rd[e_q[bscs_pkg::BitSelW-1:0]]) begin
          c2_d = ScW'(c2_q + ScW'(1));
          if (ce == 2'd1) c1_d = ScW'(c1_q + ScW'(1));
        end
        s_d = ScW'(s_q + ScW'(1));
        state_d = StCntRd;
      end
      // Rank of e: elements with a lower count, or an equal one and lower index.
      StSrtKey: state_d = StSrtKey2;
      StSrtKey2: begin
        key0_d = cnt0_rd; key1_d = cnt1_rd;
        j_d = '0; rk0_d = '0; rk1_d = '0;
        state_d = StSrtRd;
      end
      StSrtRd: begin
        if (j_q == effw_q) begin
          e_d = WW'(e_q + WW'(1));
          if (WW'(e_q + WW'(1)) == effw_q) begin
            for (int b = 0; b < Ne; b++) r_d[b] = (WW'(b) < effw_q);
            dep_d = '0;
            state_d = StNode;
          end else begin
            state_d = StSrtKey;
          end
        end else begin
          state_d = StSrtUse;
        end
      end
      StSrtUse: begin
        if (cnt0_rd < key0_q || (cnt0_rd == key0_q && j_q < e_q)) rk0_d = EW'(rk0_q + EW'(1));
        if (cnt1_rd < key1_q || (cnt1_rd == key1_q && j_q < e_q)) rk1_d = EW'(rk1_q + EW'(1));
        j_d = WW'(j_q + WW'(1));
        state_d = StSrtRd;
      end
      StNode: begin
        i_d = '0;
        state_d = (cap_q == '0) ? StFail : StFindRd;
      end
      // First uncovered element in this level's order.
      StFindRd: state_d = (i_q == effw_q) ? StFail : StFindUse;
      StFindUse: begin
        if (r_q[fe]) begin
          row_d = fe; s_d = '0;
          state_d = StSetRd;
        end else begin
          i_d = WW'(i_q + WW'(1));
          state_d = StFindRd;
        end
      end
      StSetRd: state_d = (s_q == effs_q) ? StFail : StSetUse;
      StSetUse: begin
        if ((lv2 || ce == 2'd1) && mask_rd[row_q[bscs_pkg::BitSelW-1:0]]) begin
          c_d = ce; wk_d = '0;
          state_d = StTwRd;
        end else begin
          s_d = ScW'(s_q + ScW'(1));
          state_d = StSetRd;
        end
      end
      StTwRd: state_d = StTwUse;
      StTwUse: begin
        t_d[wk_q*Wb +: Wb] = r_q[wk_q*Wb +: Wb] & ~mask_rd;
        wk_d = SW'(wk_q + SW'(1));
        state_d = (wk_q == SW'(bscs_pkg::NWords - 1)) ? StTest : StTwRd;
      end
      StTest: begin
        if (t_zero) begin
          stk_s_d[dep_q] = s_q[SiW-1:0];
          k_d = dep_q;
          state_d = StEmit;
        end else if (BW'(c_q) == cap_q) begin
          s_d = ScW'(s_q + ScW'(1));
          state_d = StSetRd;
        end else begin
          stk_r_d[dep_q]   = r_q;
          stk_cap_d[dep_q] = cap_q;
          stk_s_d[dep_q]   = s_q[SiW-1:0];
          stk_row_d[dep_q] = row_q;
          dep_d = DW'(dep_q + DW'(1));
          r_d   = t_q;
          cap_d = BW'(cap_q - BW'(c_q));
          state_d = StNode;
        end
      end
      // Backtrack into the parent and move on to its next set.
      StFail: begin
        if (dep_q == '0) begin
          state_d = StUnsat;
        end else begin
          dep_d = dep_m1;
          r_d   = stk_r_q[dep_m1];
          cap_d = stk_cap_q[dep_m1];
          row_d = stk_row_q[dep_m1];
          s_d   = ScW'(ScW'(stk_s_q[dep_m1]) + ScW'(1));
          state_d = StSetRd;
        end
      end
      StEmit: begin
        if (out_free) begin
          ov_d = 1'b1;
          o_sat_d = 1'b1; o_has_d = 1'b1;
          o_idx_d = stk_s_q[k_q];
          o_last_d = (k_q == '0);
          if (k_q == '0) state_d = StIdle;
          else k_d = DW'(k_q - DW'(1));
        end
      end
      StUnsat: begin
        if (out_free) begin
          ov_d = 1'b1;
          o_sat_d = 1'b0; o_has_d = 1'b0; o_idx_d = '0; o_last_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
      uw_q    <= WW'(Ne);
      bud_q   <= BW'(Nb);
      sc_q    <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      uw_q    <= uw_d;
      bud_q   <= bud_d;
      sc_q    <= sc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_sat_q <= o_sat_d; o_has_q <= o_has_d; o_idx_q <= o_idx_d; o_last_q <= o_last_d;
    effw_q <= effw_d; effs_q <= effs_d;
    e_q <= e_d; j_q <= j_d; i_q <= i_d; s_q <= s_d;
    c1_q <= c1_d; c2_q <= c2_d; key0_q <= key0_d; key1_q <= key1_d;
    rk0_q <= rk0_d; rk1_q <= rk1_d; row_q <= row_d;
    r_q <= r_d; t_q <= t_d; cap_q <= cap_d; c_q <= c_d;
    dep_q <= dep_d; k_q <= k_d; wk_q <= wk_d;
    stk_r_q <= stk_r_d; stk_cap_q <= stk_cap_d; stk_s_q <= stk_s_d; stk_row_q <= stk_row_d;
  end
endmodule

FILE: src/bscs_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bscs_props (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_mode_i,
  input logic out_valid_i,
  input logic out_ready_i
);
  logic search_acc, load_acc;

  assign search_acc = in_valid_i && in_ready_i && in_mode_i;
  assign load_acc   = in_valid_i && in_ready_i && !in_mode_i;

  `CHK_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !out_valid_i)
  `CHK_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)
  `CHK_ASSERT(a_search_busy, clk_i, rst_ni, search_acc |=> !in_ready_i)
  `CHK_ASSERT(a_load_silent, clk_i, rst_ni, load_acc && !out_valid_i |=> !out_valid_i)
endmodule

bind budgeted_set_cover_search_unit bscs_props u_bscs_props (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_i.valid),
  .in_ready_i(in_i.ready),
  .in_mode_i(in_i.mode),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready)
);
